// ===== src/chunked_body_decoder_macros.svh =====
// Assertion macros shared by the chunked body decoder RTL.
`ifndef CHUNKED_BODY_DECODER_MACROS_SVH
`define CHUNKED_BODY_DECODER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CBD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chunked body decoder: assertion failed");

// Next-cycle implication, disabled in reset.
`define CBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chunked body decoder: assertion failed");

`endif

// ===== src/cbd_pkg.sv =====
// Constants and result codes for the chunked body decoder.
`timescale 1ns / 1ps
package cbd_pkg;

   localparam int SIZE_BITS   = 32;
   localparam int LINE_BUFFER = 64;
   localparam int LINE_W      = $clog2(LINE_BUFFER);

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SEMI  = 8'h3B;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_DATA = 2'd1,
      KIND_DONE = 2'd2,
      KIND_ERR  = 2'd3
   } kind_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

// ===== src/chunked_body_decoder.sv =====
// Chunked transfer body decoder: size-line parser, payload pass-through, trailer check.
//
//  channel  direction  tdata               tuser              tlast
//  req_     in         [7:0] in_byte       -                  final_byte
//  rsp_     out        [7:0] payload_byte  [1:0] result_kind  -
//
// One byte per cycle while rsp_ is not stalled; each input transaction gives one registered result in the next cycle.
// The parser state and the result register update in the same cycle; the result
// register acts as the output stage, so a new byte is taken while the consumer drains.
// A stall on rsp_ holds req_tready low until the result is taken.
// reset (synchronous) returns to the size-line phase with all counts cleared.
`timescale 1ns / 1ps
`include "chunked_body_decoder_macros.svh"

module chunked_body_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // final_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output logic [1:0] rsp_tuser    // [1:0] result_kind
);
   import cbd_pkg::*;

   typedef enum logic [2:0] {
      PH_LINE = 3'd0,
      PH_DATA = 3'd1,
      PH_TCR  = 3'd2,
      PH_TLF  = 3'd3,
      PH_DONE = 3'd4,
      PH_ERR  = 3'd5
   } phase_type;

   phase_type             phase_ff,   phase_in;
   logic [SIZE_BITS-1:0]  size_ff,    size_in;
   logic [LINE_W-1:0]     len_ff,     len_in;
   logic                  crp_ff,     crp_in;
   logic                  begun_ff,   begun_in;
   logic                  stopped_ff, stopped_in;
   logic                  rsp_valid_ff;
   kind_type              rsp_kind_ff, kind_in;
   logic [7:0]            rsp_data_ff, pay_in;
   logic                  accept;
   hex_type               hex;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign hex        = hex_decode(req_tdata);

   always_comb begin
      logic [LINE_W:0] ln;
      logic            st;
      logic            fail;
      phase_in   = phase_ff;
      size_in    = size_ff;
      len_in     = len_ff;
      crp_in     = crp_ff;
      begun_in   = begun_ff;
      stopped_in = stopped_ff;
      kind_in    = KIND_NONE;
      pay_in     = '0;
      ln         = {1'b0, len_ff};
      st         = stopped_ff;
      fail       = 1'b0;
      case (phase_ff)
         PH_LINE: begin
            if (crp_ff && req_tdata == CH_LF) begin
               if (size_ff == '0) begin
                  kind_in  = KIND_DONE;
                  phase_in = PH_DONE;
               end else if (req_tlast) begin
                  kind_in  = KIND_ERR;
                  phase_in = PH_ERR;
               end else begin
                  phase_in = PH_DATA;
               end
            end else begin
               // lone CR counts as a line byte and stops digit collection
               if (crp_ff) begin
                  ln = ln + 1'b1;
                  st = 1'b1;
                  if (ln >= (LINE_W+1)'(LINE_BUFFER)) fail = 1'b1;
               end
               crp_in = (req_tdata == CH_CR);
               if (req_tdata != CH_CR && !fail) begin
                  ln = ln + 1'b1;
                  if (ln >= (LINE_W+1)'(LINE_BUFFER)) begin
                     fail = 1'b1;
                  end else if (!st) begin
                     if (!begun_ff && (req_tdata == CH_SPACE || req_tdata == CH_TAB)) begin
                        st = 1'b0;
                     end else if (!hex.valid) begin
                        st = 1'b1;
                     end else if (size_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
                        fail = 1'b1;
                     end else begin
                        size_in  = {size_ff[SIZE_BITS-5:0], hex.value};
                        begun_in = 1'b1;
                     end
                  end
               end
               len_in     = ln[LINE_W-1:0];
               stopped_in = st;
               if (fail || req_tlast) begin
                  kind_in  = KIND_ERR;
                  phase_in = PH_ERR;
               end
            end
         end
         PH_DATA: begin
            if (req_tlast) begin
               kind_in  = KIND_ERR;
               phase_in = PH_ERR;
            end else begin
               kind_in = KIND_DATA;
               pay_in  = req_tdata;
               size_in = size_ff - 1'b1;
               if (size_ff == SIZE_BITS'(1)) phase_in = PH_TCR;
            end
         end
         PH_TCR: begin
            if (req_tdata != CH_CR || req_tlast) begin
               kind_in  = KIND_ERR;
               phase_in = PH_ERR;
            end else begin
               phase_in = PH_TLF;
            end
         end
         PH_TLF: begin
            if (req_tdata != CH_LF || req_tlast) begin
               kind_in  = KIND_ERR;
               phase_in = PH_ERR;
            end else begin
               phase_in   = PH_LINE;
               size_in    = '0;
               len_in     = '0;
               crp_in     = 1'b0;
               begun_in   = 1'b0;
               stopped_in = 1'b0;
            end
         end
         PH_DONE, PH_ERR: begin
            phase_in = phase_ff;
         end
         default: begin
            kind_in  = KIND_ERR;
            phase_in = PH_ERR;
         end
      endcase
      // end of body: next byte starts a fresh one
      if (req_tlast) begin
         phase_in   = PH_LINE;
         size_in    = '0;
         len_in     = '0;
         crp_in     = 1'b0;
         begun_in   = 1'b0;
         stopped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LINE;
         size_ff      <= '0;
         len_ff       <= '0;
         crp_ff       <= 1'b0;
         begun_ff     <= 1'b0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            size_ff      <= size_in;
            len_ff       <= len_in;
            crp_ff       <= crp_in;
            begun_ff     <= begun_in;
            stopped_ff   <= stopped_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_kind_ff <= kind_in;
         rsp_data_ff <= pay_in;
      end
   end

   `CBD_ASSERT_NOW(a_data_size_nonzero, clock, reset, phase_ff == PH_DATA, size_ff != '0)
   `CBD_ASSERT_NEXT(a_last_resets, clock, reset, accept && req_tlast, phase_ff == PH_LINE && size_ff == '0 && len_ff == '0)
   `CBD_ASSERT_NOW(a_payload_only_data, clock, reset, rsp_valid_ff && rsp_kind_ff != KIND_DATA, rsp_data_ff == 8'd0)

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the chunked body decoder: byte streams with random idling.
`timescale 1ns / 1ps

module testbench;
   import cbd_pkg::*;

   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum logic [2:0] {
      BODY_LINE, BODY_DATA, BODY_TRAIL_CR, BODY_TRAIL_LF, BODY_DONE, BODY_ERROR
   } body_phase_type;

   typedef struct {
      kind_type   kind;
      logic [7:0] payload;
   } decode_result_type;

   class chunk_decode_board;
      body_phase_type    phase;
      logic [63:0]       size_left;
      int                line_count;
      bit                cr_seen;
      bit                digits_on;
      bit                digits_off;
      decode_result_type expected_q[$];
      int                errors;
      int                kind_count[4];

      function new();
         phase  = BODY_LINE;
         errors = 0;
         clear_line();
      endfunction

      function void clear_line();
         size_left  = '0;
         line_count = 0;
         cr_seen    = 0;
         digits_on  = 0;
         digits_off = 0;
      endfunction

      function int digit_of(logic [7:0] c);
         if (c inside {[8'h30:8'h39]}) return int'(c) - 48;
         if (c inside {[8'h61:8'h66]}) return int'(c) - 87;
         if (c inside {[8'h41:8'h46]}) return int'(c) - 55;
         return -1;
      endfunction

      // one byte of the size line; 0 means framing error
      function bit line_step(logic [7:0] c);
         int d;
         line_count++;
         if (line_count >= LINE_BUFFER) return 0;
         if (digits_off) return 1;
         if (!digits_on && (c == CH_SPACE || c == CH_TAB)) return 1;
         d = digit_of(c);
         if (d < 0) begin
            digits_off = 1;
            return 1;
         end
         if ((size_left >> (SIZE_BITS - 4)) != 0) return 0;
         size_left = (size_left << 4) | 64'(d);
         digits_on = 1;
         return 1;
      endfunction

      function void take_byte(logic [7:0] c, logic fin);
         decode_result_type r;
         bit bad;
         r.kind    = KIND_NONE;
         r.payload = 8'h00;
         bad       = 0;
         case (phase)
            BODY_LINE: begin
               if (cr_seen && c == CH_LF) begin
                  if (size_left == 0) begin
                     r.kind = KIND_DONE;
                     phase  = BODY_DONE;
                  end else if (fin) begin
                     bad = 1;
                  end else begin
                     phase = BODY_DATA;
                  end
               end else begin
                  if (cr_seen) begin
                     cr_seen = 0;
                     if (!line_step(CH_CR)) bad = 1;
                  end
                  if (!bad) begin
                     if (c == CH_CR) cr_seen = 1;
                     else if (!line_step(c)) bad = 1;
                  end
                  if (fin) bad = 1;
               end
            end
            BODY_DATA: begin
               if (fin) begin
                  bad = 1;
               end else begin
                  r.kind    = KIND_DATA;
                  r.payload = c;
                  size_left--;
                  if (size_left == 0) phase = BODY_TRAIL_CR;
               end
            end
            BODY_TRAIL_CR: begin
               if (c != CH_CR || fin) bad = 1;
               else phase = BODY_TRAIL_LF;
            end
            BODY_TRAIL_LF: begin
               if (c != CH_LF || fin) begin
                  bad = 1;
               end else begin
                  clear_line();
                  phase = BODY_LINE;
               end
            end
            default: ;
         endcase
         if (bad) begin
            r.kind = KIND_ERR;
            phase  = BODY_ERROR;
         end
         if (fin) begin
            phase = BODY_LINE;
            clear_line();
         end
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [1:0] kind, logic [7:0] payload);
         decode_result_type r;
         if (expected_q.size() == 0) begin
            $error("unexpected result transaction: result_kind %0d payload_byte %02h",
                   kind, payload);
            errors++;
            return;
         end
         r = expected_q.pop_front();
         kind_count[r.kind]++;
         if (kind !== r.kind) begin
            $error("result_kind: expected %0d, actual %0d", r.kind, kind);
            errors++;
         end
         if (payload !== r.payload) begin
            $error("payload_byte: expected %02h, actual %02h", r.payload, payload);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   chunk_decode_board board = new();
   logic [7:0]        body_q[$];
   bit                no_idle   = 0;
   int                sent      = 0;
   int                bodies    = 0;
   int                cycles    = 0;

   chunked_body_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.take_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tuser, rsp_tdata);
      end
   end

   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic send_body();
      for (int i = 0; i < body_q.size(); i++) send_byte(body_q[i], i == body_q.size() - 1);
      req_tvalid <= 1'b0;
      bodies++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
   endtask

   task automatic push_size_line(input logic [31:0] size);
      string hx;
      logic [7:0] ch;
      repeat ($urandom_range(0, 2)) body_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      hx = $sformatf("%0h", size);
      if ($urandom_range(0, 3) == 0) hx = {"0", hx};
      for (int i = 0; i < hx.len(); i++) begin
         ch = hx[i];
         if (ch >= 8'h61 && $urandom_range(0, 1)) ch = ch - 8'h20;
         body_q.push_back(ch);
      end
      if ($urandom_range(0, 3) == 0) push_text(";name=v");
      body_q.push_back(CH_CR);
      body_q.push_back(CH_LF);
   endtask

   task automatic build_body();
      int size;
      int mode;
      int idx;
      logic [7:0] odd[4];
      odd = '{CH_CR, CH_LF, CH_SEMI, CH_SPACE};
      body_q.delete();
      repeat ($urandom_range(0, 3)) begin
         size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
         push_size_line(size);
         repeat (size) body_q.push_back(8'($urandom_range(0, 255)));
         body_q.push_back(CH_CR);
         body_q.push_back(CH_LF);
      end
      if ($urandom_range(0, 4) == 0) begin
         body_q.push_back(CH_CR);
         body_q.push_back(CH_LF);
      end else begin
         push_size_line(0);
      end
      repeat ($urandom_range(0, 2)) body_q.push_back(8'($urandom_range(0, 255)));
      mode = $urandom_range(0, 9);
      idx  = $urandom_range(0, body_q.size() - 1);
      case (mode)
         6: if (body_q.size() > 1) body_q = body_q[0:$urandom_range(0, body_q.size() - 2)];
         7: body_q[idx] = 8'($urandom_range(0, 255));
         8: body_q[idx] = odd[$urandom_range(0, 3)];
         9: begin
            body_q.delete();
            if ($urandom_range(0, 1)) begin
               body_q.push_back("1");
               repeat ($urandom_range(60, 66)) body_q.push_back("x");
            end else begin
               body_q.push_back($urandom_range(0, 1) ? "f" : "1");
               repeat ($urandom_range(8, 9)) body_q.push_back(8'("0" + $urandom_range(0, 9)));
            end
            body_q.push_back(CH_CR);
            body_q.push_back(CH_LF);
            repeat ($urandom_range(1, 4)) body_q.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
   endtask

   initial begin : stimulus
      int random_start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // tab before digits, extension, one payload byte, then the closing zero line
      body_q = '{CH_TAB, "1", CH_SEMI, "e", CH_CR, CH_LF, 8'hFF, CH_CR, CH_LF,
                 "0", CH_CR, CH_LF};
      send_body();
      // lone CR on the size line, no digits, so decoding ends
      body_q = '{CH_CR, CH_CR, CH_LF};
      send_body();
      // payload followed by a bad trailer byte
      body_q = '{"1", CH_CR, CH_LF, 8'h00, "X"};
      send_body();
      // body ending on the LF of a nonzero size line
      body_q = '{"1", CH_CR, CH_LF};
      send_body();
      // size that does not fit
      body_q = '{"1", "0", "0", "0", "0", "0", "0", "0", "0"};
      send_body();

      random_start = sent;
      while (sent - random_start < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         build_body();
         send_body();
      end
      no_idle = 0;

      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d bodies, %0d byte transactions in", bodies, sent);
      $display("results: %0d idle, %0d payload, %0d done, %0d framing error",
               board.kind_count[KIND_NONE], board.kind_count[KIND_DATA],
               board.kind_count[KIND_DONE], board.kind_count[KIND_ERR]);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/cbd_pkg.sv
src/chunked_body_decoder.sv
bench/testbench.sv
